>>> src/uint128_divider_assert.svh
// ----------------------------------------------------------------------------
// uint128_divider assertion macros
// Shared concurrent assertion forms for the divider's checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef UINT128_DIVIDER_ASSERT_SVH
`define UINT128_DIVIDER_ASSERT_SVH

// Checked only outside reset.
`define U128DIV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset as well.
`define U128DIV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/u128div_pkg.sv
// ----------------------------------------------------------------------------
// u128div_pkg
// Widths and shared types of the 128-bit unsigned divider.
// ----------------------------------------------------------------------------
package u128div_pkg;

  localparam int WORD_W = 64;
  localparam int DATA_W = 2 * WORD_W;
  localparam int CNT_W  = $clog2(DATA_W);

  // Status of the iteration unit as seen by the top level
  typedef struct packed {
    logic idle;
    logic done;
  } core_status_t;

endpackage

>>> src/u128div_core.sv
// ----------------------------------------------------------------------------
// u128div_core
// Radix-2 restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module u128div_core import u128div_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                take,
  input  logic [DATA_W-1:0]   dividend,
  input  logic [DATA_W-1:0]   divisor,
  output core_status_t        status,
  output logic [DATA_W-1:0]   quotient,
  output logic [DATA_W-1:0]   remainder,
  output logic                divide_by_zero
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DONE
  } state_t;

  state_t              state;
  logic [DATA_W-1:0]   nq;      // dividend bits shift out the top, quotient bits in
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   div;
  logic [CNT_W-1:0]    count;
  logic                dz;

  logic [DATA_W:0]     shifted;
  logic [DATA_W+1:0]   diff;
  logic                fits;
  logic [DATA_W-1:0]   rem_next;

  // Shifted partial remainder keeps its carry bit, so a divisor of 2^127
  // or more still compares exactly.
  always_comb begin
    shifted  = {rem, nq[DATA_W-1]};
    diff     = {1'b0, shifted} - {2'b00, div};
    fits     = ~diff[DATA_W+1];
    rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            div   <= divisor;
            count <= CNT_W'(DATA_W - 1);
            if (divisor == '0) begin
              dz    <= 1'b1;
              nq    <= '0;
              rem   <= dividend;
              state <= DONE;
            end else begin
              dz    <= 1'b0;
              nq    <= dividend;
              rem   <= '0;
              state <= RUN;
            end
          end
        end
        RUN: begin
          nq    <= {nq[DATA_W-2:0], fits};
          rem   <= rem_next;
          count <= count - 1'b1;
          if (count == '0) begin
            state <= DONE;
          end
        end
        DONE: begin
          // hold the result until the output stage takes it
          if (take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign status.idle    = (state == IDLE);
  assign status.done    = (state == DONE);
  assign quotient       = nq;
  assign remainder      = rem;
  assign divide_by_zero = dz;

endmodule

>>> src/uint128_divider.sv
// ----------------------------------------------------------------------------
// uint128_divider
// Unsigned 128-bit divider giving floor quotient and remainder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries the dividend and divisor as
//   64-bit halves. A transfer starts one division; in_ready is high only
//   while the iteration unit is free.
//   Output channel (out_valid/out_ready) carries quotient, remainder and the
//   divide_by_zero flag from an output register.
//   The input transfer loads the iteration unit, which runs its restoring
//   steps, one per quotient bit; the result then moves into the output
//   register and out_valid rises. A zero divisor skips the steps.
//   A new item is taken only once the result of the last one has moved into
//   the output register, as the single shift-subtract unit retires one
//   quotient bit per cycle.
//   A stalled receiver holds the output register; the next item may still
//   enter and run, and waits in the iteration unit once it is done.
//   Reset (rst, synchronous) drops any item in flight and clears out_valid.
// ----------------------------------------------------------------------------
module uint128_divider import u128div_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] dividend_upper,
  input  logic [WORD_W-1:0] dividend_lower,
  input  logic [WORD_W-1:0] divisor_upper,
  input  logic [WORD_W-1:0] divisor_lower,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] quotient_upper,
  output logic [WORD_W-1:0] quotient_lower,
  output logic [WORD_W-1:0] remainder_upper,
  output logic [WORD_W-1:0] remainder_lower,
  output logic              divide_by_zero
);

  core_status_t        status;
  logic                start;
  logic                load;
  logic [DATA_W-1:0]   core_quotient;
  logic [DATA_W-1:0]   core_remainder;
  logic                core_dz;

  assign in_ready = status.idle;
  assign start    = in_valid & status.idle;
  // advance the finished result when the output register is free or emptying
  assign load     = status.done & (~out_valid | out_ready);

  u128div_core u_core (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .take           (load),
    .dividend       ({dividend_upper, dividend_lower}),
    .divisor        ({divisor_upper, divisor_lower}),
    .status         (status),
    .quotient       (core_quotient),
    .remainder      (core_remainder),
    .divide_by_zero (core_dz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      quotient_upper  <= core_quotient[DATA_W-1:WORD_W];
      quotient_lower  <= core_quotient[WORD_W-1:0];
      remainder_upper <= core_remainder[DATA_W-1:WORD_W];
      remainder_lower <= core_remainder[WORD_W-1:0];
      divide_by_zero  <= core_dz;
    end
  end

endmodule

>>> src/u128div_checker.sv
// ----------------------------------------------------------------------------
// u128div_checker
// Port-level assertions for the divider, bound to the top level.
// ----------------------------------------------------------------------------
`include "uint128_divider_assert.svh"

module u128div_checker import u128div_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [WORD_W-1:0] dividend_upper,
  input logic [WORD_W-1:0] dividend_lower,
  input logic [WORD_W-1:0] divisor_upper,
  input logic [WORD_W-1:0] divisor_lower,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] quotient_upper,
  input logic [WORD_W-1:0] quotient_lower,
  input logic [WORD_W-1:0] remainder_upper,
  input logic [WORD_W-1:0] remainder_lower,
  input logic              divide_by_zero
);

  logic [4*WORD_W:0]   result_bits;
  logic [4*WORD_W-1:0] operand_bits;
  logic [DATA_W-1:0]   quotient_bits;
  logic                out_stall;
  logic                in_stall;
  logic                in_xfer;
  logic                out_dz;

  assign result_bits   = {quotient_upper, quotient_lower, remainder_upper, remainder_lower,
                          divide_by_zero};
  assign operand_bits  = {dividend_upper, dividend_lower, divisor_upper, divisor_lower};
  assign quotient_bits = {quotient_upper, quotient_lower};
  assign out_stall     = out_valid & ~out_ready;
  assign in_stall      = in_valid & ~in_ready;
  assign in_xfer       = in_valid & in_ready;
  assign out_dz        = out_valid & divide_by_zero;

  // a stalled result holds
  `U128DIV_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(result_bits), "result not held")

  // a waiting input item holds
  `U128DIV_ASSERT(a_in_hold, in_stall |=> in_valid && $stable(operand_bits), "input not held")

  // an accepted item keeps the unit busy on the next cycle
  `U128DIV_ASSERT(a_busy_after_transfer, in_xfer |=> !in_ready, "unit free after transfer")

  // zero divisor gives a zero quotient
  `U128DIV_ASSERT(a_dz_quotient, out_dz |-> quotient_bits == '0, "quotient set on zero divisor")

  // reset drops any pending result and frees the unit
  `U128DIV_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && in_ready, "not clear after reset")

endmodule

bind uint128_divider u128div_checker u_checker (.*);
